[rtl/lps_pkg.sv]
// Shared types and constants for the lamp persistence PWM scanner.
package lps_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RISE_GAIN = 2'd0;
    localparam logic [1:0] CFG_FALL_GAIN = 2'd1;
    localparam logic [1:0] CFG_DEADBAND  = 2'd2;

    localparam logic [15:0] RISE_GAIN_RST = 16'd13107;
    localparam logic [15:0] FALL_GAIN_RST = 16'd5243;
    localparam logic [15:0] DEADBAND_RST  = 16'd1024;

    localparam int MAX_OUT_ROWS = 8;
    localparam int MAX_OUT_COLS = 12;

    typedef struct packed {
        logic [15:0] rise_gain;
        logic [15:0] fall_gain;
        logic [15:0] deadband;
    } t_cfg;

    // Command handed from the front end to the back end.
    typedef struct packed {
        logic        is_tick;
        logic [6:0]  idx;
        logic [15:0] target;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  row;
        logic [11:0] mask;
        logic [5:0]  step;
        logic        last;
    } t_result;

endpackage

[rtl/lps_queue.sv]
// Two-entry first-in first-out queue of packed words.
module lps_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

[rtl/lps_front.sv]
// Front end: accepts requests, computes sample targets with a serial divider.
module lps_front #(
    parameter int LAMPS = 96
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_mode,
    input  logic [6:0]         i_lamp_index,
    input  logic [31:0]        i_on_count,
    input  logic [31:0]        i_frame_count,
    output logic               o_cmd_push,
    output lps_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_full
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate       r_state;
    lps_pkg::t_cmd r_cmd;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic [15:0]   r_quo;
    logic [3:0]    r_cnt;
    logic [32:0]   rem2;
    logic          qbit;
    logic [15:0]   n_quo;

    assign o_full     = (r_state != F_IDLE);
    assign o_cmd_push = (r_state == F_PUSH);
    assign o_cmd      = r_cmd;

    always_comb begin
        rem2  = {r_rem[31:0], 1'b0};
        qbit  = (rem2 >= {1'b0, r_den});
        n_quo = {r_quo[14:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_cmd.is_tick <= i_mode;
                        r_cmd.idx     <= i_lamp_index;
                        r_cmd.target  <= 16'd0;
                        r_rem         <= {1'b0, i_on_count};
                        r_den         <= i_frame_count;
                        r_quo         <= 16'd0;
                        r_cnt         <= 4'd0;
                        if (i_mode) begin
                            r_state <= F_PUSH;
                        end else if (32'(i_lamp_index) >= LAMPS) begin
                            r_state <= F_IDLE;
                        end else if (i_frame_count == 32'd0) begin
                            r_state <= F_PUSH;
                        end else if (i_on_count >= i_frame_count) begin
                            // Ratio of one or more saturates at full scale.
                            r_cmd.target <= 16'hFFFF;
                            r_state      <= F_PUSH;
                        end else begin
                            r_state <= F_DIV;
                        end
                    end
                end
                F_DIV: begin
                    if (qbit) begin
                        r_rem <= rem2 - {1'b0, r_den};
                    end else begin
                        r_rem <= rem2;
                    end
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_cmd.target <= n_quo;
                        r_state      <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_cmd_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

[rtl/lps_back.sv]
// Back end: holds lamp state, settles brightness on wrap and scans the rows.
module lps_back #(
    parameter int ROWS   = 8,
    parameter int COLS   = 12,
    parameter int LEVELS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lps_pkg::t_cfg     i_cfg,
    input  logic              i_cmd_empty,
    input  lps_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output lps_pkg::t_result  o_res,
    input  logic              i_res_full
);
    localparam int LAMPS  = ROWS * COLS;
    localparam int ADDR_W = (LAMPS > 1) ? $clog2(LAMPS) : 1;
    localparam int NR     = (ROWS < lps_pkg::MAX_OUT_ROWS) ? ROWS : lps_pkg::MAX_OUT_ROWS;
    localparam int NC     = (COLS < lps_pkg::MAX_OUT_COLS) ? COLS : lps_pkg::MAX_OUT_COLS;
    localparam int RW     = (NR > 1) ? $clog2(NR) : 1;
    localparam int CW     = (NC > 1) ? $clog2(NC) : 1;
    localparam int SW     = $clog2(LEVELS + 1);
    localparam int MW     = $clog2(2 * LEVELS);
    localparam int THR_Q  = 65536 / LEVELS;
    localparam int THR_R  = 65536 % LEVELS;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SET_RD   = 7'b0000010,
        S_SET_CALC = 7'b0000100,
        S_SET_WR   = 7'b0001000,
        S_SCAN_RD  = 7'b0010000,
        S_SCAN_CMP = 7'b0100000,
        S_OUT      = 7'b1000000
    } t_bstate;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_RISE = 2'd1,
        OP_FALL = 2'd2
    } t_op;

    t_bstate            r_state;
    logic [15:0]        r_bri_mem [LAMPS];
    logic [15:0]        r_tgt_mem [LAMPS];
    logic [LAMPS-1:0]   r_bri_vld;
    logic [LAMPS-1:0]   r_tgt_vld;
    logic [15:0]        r_bri_q;
    logic [15:0]        r_tgt_q;
    logic               r_bri_q_vld;
    logic               r_tgt_q_vld;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_base;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [11:0]        r_mask;
    logic [SW-1:0]      r_step;
    logic [16:0]        r_thr;
    logic [MW-1:0]      r_thr_rem;
    logic [32:0]        r_prod;
    logic [15:0]        r_b;
    t_op                r_op;
    logic [15:0]        bri;
    logic [15:0]        tgt;
    logic [15:0]        diff;
    logic [MW-1:0]      rem_sum;
    logic [ADDR_W-1:0]  next_base;
    logic               tgt_we;
    logic [ADDR_W-1:0]  tgt_addr;
    logic               bri_we;
    logic [15:0]        bri_new;

    assign bri       = r_bri_q_vld ? r_bri_q : 16'd0;
    assign tgt       = r_tgt_q_vld ? r_tgt_q : 16'd0;
    assign diff      = (tgt > bri) ? (tgt - bri) : (bri - tgt);
    assign rem_sum   = r_thr_rem + MW'(THR_R);
    assign next_base = ADDR_W'((ADDR_W + 1)'(r_base) + (ADDR_W + 1)'(COLS));
    assign tgt_addr  = ADDR_W'(i_cmd.idx);
    assign tgt_we    = (r_state == S_IDLE) && !i_cmd_empty && !i_cmd.is_tick;
    assign bri_we    = (r_state == S_SET_WR) && (r_op != OP_NONE);
    assign bri_new   = (r_op == OP_RISE) ? (r_b + r_prod[31:16]) : (r_b - r_prod[31:16]);
    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;

    assign o_res_push = (r_state == S_OUT);
    assign o_res.row  = 3'(r_row);
    assign o_res.mask = r_mask;
    assign o_res.step = 6'(r_step);
    assign o_res.last = (r_row == RW'(NR - 1));

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[tgt_addr] <= i_cmd.target;
        end
        if (bri_we) begin
            r_bri_mem[r_addr] <= bri_new;
        end
        r_bri_q <= r_bri_mem[r_addr];
        r_tgt_q <= r_tgt_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bri_vld   <= '0;
            r_tgt_vld   <= '0;
            r_bri_q_vld <= 1'b0;
            r_tgt_q_vld <= 1'b0;
        end else begin
            if (tgt_we) begin
                r_tgt_vld[tgt_addr] <= 1'b1;
            end
            if (bri_we) begin
                r_bri_vld[r_addr] <= 1'b1;
            end
            r_bri_q_vld <= r_bri_vld[r_addr];
            r_tgt_q_vld <= r_tgt_vld[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= SW'(LEVELS);
            r_thr     <= 17'(65536);
            r_thr_rem <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty && i_cmd.is_tick) begin
                        r_addr <= '0;
                        r_base <= '0;
                        r_row  <= '0;
                        r_col  <= '0;
                        r_mask <= '0;
                        if (r_step == SW'(LEVELS)) begin
                            r_step    <= SW'(1);
                            r_thr     <= 17'(THR_Q);
                            r_thr_rem <= MW'(THR_R);
                            r_state   <= S_SET_RD;
                        end else begin
                            r_step <= r_step + SW'(1);
                            // Threshold tracks step * 65536 / LEVELS incrementally.
                            if (rem_sum >= MW'(LEVELS)) begin
                                r_thr     <= r_thr + 17'(THR_Q) + 17'd1;
                                r_thr_rem <= rem_sum - MW'(LEVELS);
                            end else begin
                                r_thr     <= r_thr + 17'(THR_Q);
                                r_thr_rem <= rem_sum;
                            end
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SET_RD: begin
                    r_state <= S_SET_CALC;
                end
                S_SET_CALC: begin
                    r_b <= bri;
                    if (diff <= i_cfg.deadband) begin
                        r_op <= OP_NONE;
                    end else if (tgt > bri) begin
                        r_op   <= OP_RISE;
                        r_prod <= 33'((17'd65536 - 17'(bri)) * 17'(i_cfg.rise_gain));
                    end else begin
                        r_op   <= OP_FALL;
                        r_prod <= 33'(bri * i_cfg.fall_gain);
                    end
                    r_state <= S_SET_WR;
                end
                S_SET_WR: begin
                    if (r_addr == ADDR_W'(LAMPS - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_addr  <= r_addr + ADDR_W'(1);
                        r_state <= S_SET_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (17'(bri) >= r_thr) begin
                        r_mask <= r_mask | (12'd1 << r_col);
                    end
                    if (r_col == CW'(NC - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_col   <= r_col + CW'(1);
                        r_addr  <= r_addr + ADDR_W'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        if (r_row == RW'(NR - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + RW'(1);
                            r_col   <= '0;
                            r_mask  <= '0;
                            r_base  <= next_base;
                            r_addr  <= next_base;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/lamp_persistence_pwm_scanner_unit.sv]
// Top level of the lamp persistence PWM scanner.
// Usage: requests enter through push/full and are taken when push is high and
// full is low. A sample request (mode 0) sets one lamp's target from
// on_count / frame_count; it produces no result, and a lamp index at or past
// ROWS*COLS is dropped. While the ratio is below one the front end stays busy
// as the serial divider forms the 16-bit quotient. A tick request (mode 1)
// advances the PWM step and yields one result per scanned row, read through
// empty/pop; the oldest result sits on the output ports while empty is low.
// A tick scans the lamps of the first min(ROWS,8) rows and min(COLS,12)
// columns, with one brightness memory read per lamp. When the step wraps,
// the brightness update first walks every lamp through the read, calculate
// and write states (S_SET_RD, S_SET_CALC, S_SET_WR).
// Two-entry queues sit between front end and back end and on the results, so
// the front end keeps accepting while results wait. If the receiver stops
// popping, the back end stalls once the result queue fills, and the front
// end stalls once the command queue fills.
// Reset clears all brightness and targets to zero, sets the step to LEVELS and
// restores the default gains and deadband. Configuration is written with
// i_cfg_we, i_cfg_idx and i_cfg_data while the block is idle.
module lamp_persistence_pwm_scanner_unit #(
    parameter int ROWS   = 8,
    parameter int COLS   = 12,
    parameter int LEVELS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [6:0]  i_lamp_index,
    input  logic [31:0] i_on_count,
    input  logic [31:0] i_frame_count,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_row,
    output logic [11:0] o_column_mask,
    output logic [5:0]  o_pwm_step,
    output logic        o_last_row
);
    localparam int CMD_W = $bits(lps_pkg::t_cmd);
    localparam int RES_W = $bits(lps_pkg::t_result);

    lps_pkg::t_cfg    r_cfg;
    lps_pkg::t_cmd    cmd_in;
    lps_pkg::t_cmd    cmd_out;
    lps_pkg::t_result res_in;
    lps_pkg::t_result res_out;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_empty;
    logic             res_push;
    logic             res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_gain <= lps_pkg::RISE_GAIN_RST;
            r_cfg.fall_gain <= lps_pkg::FALL_GAIN_RST;
            r_cfg.deadband  <= lps_pkg::DEADBAND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lps_pkg::CFG_RISE_GAIN: r_cfg.rise_gain <= i_cfg_data;
                lps_pkg::CFG_FALL_GAIN: r_cfg.fall_gain <= i_cfg_data;
                lps_pkg::CFG_DEADBAND:  r_cfg.deadband  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lps_front #(.LAMPS(ROWS * COLS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_lamp_index (i_lamp_index),
        .i_on_count   (i_on_count),
        .i_frame_count(i_frame_count),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_full   (cmd_full)
    );

    lps_queue #(.W(CMD_W)) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (cmd_out),
        .o_empty(cmd_empty)
    );

    lps_back #(.ROWS(ROWS), .COLS(COLS), .LEVELS(LEVELS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_empty(cmd_empty),
        .i_cmd      (cmd_out),
        .o_cmd_pop  (cmd_pop),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_full (res_full)
    );

    lps_queue #(.W(RES_W)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_out),
        .o_empty(empty)
    );

    assign o_row         = res_out.row;
    assign o_column_mask = res_out.mask;
    assign o_pwm_step    = res_out.step;
    assign o_last_row    = res_out.last;
endmodule
